// File: src/xtea_pkg.sv
// xtea_pkg: shared types, constants and the round mix function for the
// XTEA block cipher pipeline. No dependencies.
`default_nettype none

package xtea_pkg;

   localparam int          XT_CYCLES    = 16;
   localparam int          KEY_COUNT    = 4;
   localparam int          CSR_AW       = 3;
   localparam logic [31:0] XT_DELTA_NEG = 32'h61C8_8647;
   localparam logic [31:0] XT_DELTA     = 32'h9E37_79B9;

   localparam logic [31:0] KEY0_RESET = 32'h03F6_07A9;
   localparam logic [31:0] KEY1_RESET = 32'h036F_5A3E;
   localparam logic [31:0] KEY2_RESET = 32'h0110_02B4;
   localparam logic [31:0] KEY3_RESET = 32'h04AB_00EA;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [KEY_COUNT-1:0][31:0] key_set_type;

   // one word in flight between cells
   typedef struct packed {
      logic        valid;
      logic        mode;
      logic [31:0] sum;
      logic [31:0] v0;
      logic [31:0] v1;
   } stage_type;

   function automatic logic [31:0] xt_mix(input logic [31:0] v);
      xt_mix = ((v << 4) ^ (v >> 5)) + v;
   endfunction

endpackage

`default_nettype wire

// File: src/xtea_cell.sv
// xtea_cell: one Feistel half-round stage, registered at its output.
// Depends on xtea_pkg.
`default_nettype none

module xtea_cell
   import xtea_pkg::*;
#(
   parameter bit ODD_STAGE = 1'b0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire key_set_type keys,
   input  wire stage_type   stage_in,
   output stage_type        stage_out
);

   stage_type   stage_ff;
   stage_type   stage_in_w;
   logic        use_low;
   logic        upd_v1;
   logic [1:0]  key_idx;
   logic [31:0] src_word;
   logic [31:0] round_f;
   logic [31:0] sum_next;

   always_comb begin
      use_low  = (stage_in.mode == logic'(ODD_STAGE));
      upd_v1   = stage_in.mode ^ logic'(ODD_STAGE);
      key_idx  = use_low ? stage_in.sum[1:0] : stage_in.sum[12:11];
      src_word = upd_v1 ? stage_in.v0 : stage_in.v1;
      round_f  = xt_mix(src_word) ^ (stage_in.sum + keys[key_idx]);

      sum_next = stage_in.sum;
      if (!ODD_STAGE) begin
         sum_next = (stage_in.mode == MODE_DECRYPT) ? stage_in.sum + XT_DELTA_NEG
                                                    : stage_in.sum - XT_DELTA_NEG;
      end

      stage_in_w       = stage_in;
      stage_in_w.sum   = sum_next;
      if (upd_v1) begin
         stage_in_w.v1 = (stage_in.mode == MODE_DECRYPT) ? stage_in.v1 - round_f
                                                         : stage_in.v1 + round_f;
      end else begin
         stage_in_w.v0 = (stage_in.mode == MODE_DECRYPT) ? stage_in.v0 - round_f
                                                         : stage_in.v0 + round_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// File: src/xtea_block_cipher_16_cycle_unit.sv
// xtea_block_cipher_16_cycle_unit: XTEA encrypt/decrypt pipeline, one cell
// per half-round, key registers and stream handshake. Uses xtea_pkg, xtea_cell.
//
//   channel | direction | contents
//   req_*   | in        | tdata {block_right, block_left}, tuser mode
//   rsp_*   | out       | tdata {result_right, result_left}
//   csr_*   | in        | key_word0..key_word3 write, index 0..3
//
// Each word passes through the chain of half-round cells, one register per
// cell; a new word is taken every clock while the output is not stalled.
// Reset clears the valid bits and loads the default key set.
// A stalled output freezes the whole chain; req_tready drops only then.
`default_nettype none

module xtea_block_cipher_16_cycle_unit
   import xtea_pkg::*;
#(
   parameter int CYCLES = XT_CYCLES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [63:0]       req_tdata,   // block_left, block_right
   input  wire logic              req_tuser,   // mode
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [63:0]            rsp_tdata,   // result_left, result_right
   input  wire logic              csr_we,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [31:0]       csr_wdata
);

   localparam int          STAGES       = 2 * CYCLES;
   localparam logic [63:0] DEC_SUM_WIDE = 64'(CYCLES) * 64'(XT_DELTA);
   localparam logic [31:0] DEC_SUM      = DEC_SUM_WIDE[31:0];

   key_set_type key_ff;
   stage_type   chain [STAGES+1];
   logic        advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= KEY0_RESET;
         key_ff[1] <= KEY1_RESET;
         key_ff[2] <= KEY2_RESET;
         key_ff[3] <= KEY3_RESET;
      end else if (csr_we && (32'(csr_addr) < KEY_COUNT)) begin
         key_ff[csr_addr[1:0]] <= csr_wdata;
      end
   end

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   assign chain[0].valid = req_tvalid;
   assign chain[0].mode  = req_tuser;
   assign chain[0].sum   = (req_tuser == MODE_DECRYPT) ? DEC_SUM : 32'h0;
   assign chain[0].v0    = req_tdata[31:0];
   assign chain[0].v1    = req_tdata[63:32];

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      xtea_cell #(
         .ODD_STAGE (1'(i % 2))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .keys      (key_ff),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   assign rsp_tvalid = chain[STAGES].valid;
   assign rsp_tdata  = {chain[STAGES].v1, chain[STAGES].v0};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output word changed while stalled");

   a_enc_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (chain[STAGES].mode == MODE_ENCRYPT) |-> chain[STAGES].sum == DEC_SUM)
      else $error("encrypt schedule ended on wrong sum");

   a_dec_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (chain[STAGES].mode == MODE_DECRYPT) |-> chain[STAGES].sum == 32'h0)
      else $error("decrypt schedule ended on wrong sum");

   a_first_cell: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> chain[1].valid)
      else $error("accepted word missing from first cell");

endmodule

`default_nettype wire

// File: test/tb_xtea_block_cipher_16_cycle_unit.sv
// tb_xtea_block_cipher_16_cycle_unit: self-checking stream testbench for the XTEA
// cipher pipeline: directed and random words under several keys, checked against
// a local XTEA predictor. Depends on xtea_pkg and xtea_block_cipher_16_cycle_unit.
`timescale 1ns / 1ps

module tb_xtea_block_cipher_16_cycle_unit;
   import xtea_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_AT_WORD   = 500;
   localparam int HOLD_CYCLES    = 150;
   localparam int PHASE_WORDS    = 306;

   typedef struct {
      logic        mode;
      logic [31:0] left;
      logic [31:0] right;
   } block_word_type;

   typedef struct {
      logic [31:0] left;
      logic [31:0] right;
   } cipher_out_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata  = '0;   // block_left, block_right
   logic              req_tuser  = 1'b0; // mode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [63:0]       rsp_tdata;         // result_left, result_right
   logic              csr_we     = 1'b0;
   logic [CSR_AW-1:0] csr_addr   = '0;
   logic [31:0]       csr_wdata  = '0;

   block_word_type block_feed[$];
   cipher_out_type expected_blocks[$];
   key_set_type    key_model;
   bit             gaps_on = 1'b1;
   int             words_out = 0;
   int             mismatches = 0;
   int             hold_left;
   bit             hold_done;
   int             quiet_cycles;

   xtea_block_cipher_16_cycle_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [31:0] round_mix(input logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

   function automatic cipher_out_type xtea_cipher(input logic mode, input logic [31:0] left,
                                                  input logic [31:0] right,
                                                  input key_set_type keys);
      logic [31:0] v0;
      logic [31:0] v1;
      logic [31:0] sum;
      cipher_out_type res;
      v0 = left;
      v1 = right;
      if (mode == MODE_ENCRYPT) begin
         sum = '0;
         for (int n = 0; n < XT_CYCLES; n++) begin
            v0 += round_mix(v1) ^ (sum + keys[sum[1:0]]);
            sum -= XT_DELTA_NEG;
            v1 += round_mix(v0) ^ (sum + keys[sum[12:11]]);
         end
      end else begin
         sum = 32'(XT_CYCLES) * XT_DELTA;
         for (int n = 0; n < XT_CYCLES; n++) begin
            v1 -= round_mix(v0) ^ (sum + keys[sum[12:11]]);
            sum += XT_DELTA_NEG;
            v0 -= round_mix(v1) ^ (sum + keys[sum[1:0]]);
         end
      end
      res.left  = v0;
      res.right = v1;
      return res;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_block(input logic mode, input logic [31:0] left,
                             input logic [31:0] right);
      block_word_type w;
      w.mode  = mode;
      w.left  = left;
      w.right = right;
      block_feed.push_back(w);
   endtask

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++)
         push_block($urandom_range(1) ? MODE_DECRYPT : MODE_ENCRYPT, pick_word(), pick_word());
   endtask

   task automatic write_key(input int index, input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_AW'(index);
      csr_wdata <= value;
      if (index < KEY_COUNT)
         key_model[index] = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_keys(input key_set_type keys);
      for (int i = 0; i < KEY_COUNT; i++)
         write_key(i, keys[i]);
   endtask

   // settled values are checked between edges
   task automatic drain();
      @(negedge clock);
      while (block_feed.size() != 0 || req_tvalid || expected_blocks.size() != 0)
         @(negedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      block_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (block_feed.size() != 0 && !(gaps_on && $urandom_range(99) < 8)) begin
            w = block_feed.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {w.right, w.left};
            req_tuser  <= w.mode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off once the pipeline is busy
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (!hold_done && words_out >= HOLD_AT_WORD) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(gaps_on && $urandom_range(99) < 8);
      end
   end

   // predict on accepted input words, check accepted output words
   always @(posedge clock) begin
      cipher_out_type exp_word;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_blocks.push_back(xtea_cipher(req_tuser, req_tdata[31:0],
                                                  req_tdata[63:32], key_model));
         if (rsp_tvalid && rsp_tready) begin
            words_out <= words_out + 1;
            if (expected_blocks.size() == 0) begin
               mismatches++;
               $error("unexpected word: result_left %h result_right %h",
                      rsp_tdata[31:0], rsp_tdata[63:32]);
            end else begin
               exp_word = expected_blocks.pop_front();
               if (rsp_tdata[31:0] !== exp_word.left) begin
                  mismatches++;
                  $error("result_left: expected %h, got %h", exp_word.left,
                         rsp_tdata[31:0]);
               end
               if (rsp_tdata[63:32] !== exp_word.right) begin
                  mismatches++;
                  $error("result_right: expected %h, got %h", exp_word.right,
                         rsp_tdata[63:32]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cipher_out_type ct;
      key_set_type keys;
      key_model = {KEY3_RESET, KEY2_RESET, KEY1_RESET, KEY0_RESET};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes in both modes under the reset key set
      for (int m = 0; m < 2; m++) begin
         push_block(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
         push_block(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         push_block(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
         push_block(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
         push_block(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
         push_block(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
         push_block(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
         push_block(m ? MODE_DECRYPT : MODE_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
      end
      // round trip: decrypt what the encrypt produces
      push_block(MODE_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
      ct = xtea_cipher(MODE_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, key_model);
      push_block(MODE_DECRYPT, ct.left, ct.right);
      drain();

      // all-zero key; writes past the last key register must change nothing
      load_keys('0);
      for (int i = KEY_COUNT; i < 2 ** CSR_AW; i++)
         write_key(i, $urandom);
      push_random(PHASE_WORDS);
      drain();

      // all-ones key; the long output hold-off lands in this phase
      load_keys('1);
      push_random(PHASE_WORDS);
      drain();

      // random key, no idling on either side
      gaps_on = 1'b0;
      for (int i = 0; i < KEY_COUNT; i++)
         keys[i] = $urandom;
      load_keys(keys);
      push_random(PHASE_WORDS);
      drain();
      gaps_on = 1'b1;

      // one-hot key words
      for (int i = 0; i < KEY_COUNT; i++)
         keys[i] = 32'h1 << $urandom_range(31);
      load_keys(keys);
      push_random(PHASE_WORDS);
      drain();

      // back to the reset key set, written explicitly
      load_keys({KEY3_RESET, KEY2_RESET, KEY1_RESET, KEY0_RESET});
      push_random(PHASE_WORDS);
      drain();

      repeat (2 * XT_CYCLES + 8) @(posedge clock);
      if (mismatches == 0 && expected_blocks.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
